// ----- rtl/host_watchdog_with_boot_grace_top_defines.svh -----
// assertion macros for the host watchdog rtl
// used by host_watchdog_with_boot_grace_top; expects clk and arst_n in scope
`ifndef HOST_WATCHDOG_WITH_BOOT_GRACE_TOP_DEFINES_SVH
`define HOST_WATCHDOG_WITH_BOOT_GRACE_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define HWDG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define HWDG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hwdg_pkg.sv -----
// types and constants for the host watchdog with boot grace
// no dependencies
package hwdg_pkg;

	// request opcodes
	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_POWER_UP = 3'd1,
		OP_ARM      = 3'd2,
		OP_STOP     = 3'd3,
		OP_WRITE    = 3'd4,
		OP_READ     = 3'd5
	} op_t;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GRACE_FACTOR = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GRACE_FLOOR  = 2'd1;

	localparam logic [2:0]  GRACE_FACTOR_RST = 3'd2;
	localparam logic [15:0] GRACE_FLOOR_RST  = 16'd180;

	localparam int SEQ_BITS_DEF = 8;
	localparam int SEQ_PORT_BITS = 8;

	localparam logic [23:0] CNT_MAX      = 24'hFF_FFFF;
	localparam logic [21:0] SEC_PER_MIN  = 22'd60;
	localparam logic [15:0] SCALE_LIMIT  = 16'h4000;

endpackage

// ----- rtl/host_watchdog_with_boot_grace_top.sv -----
// host activity watchdog with boot grace window, top level
// depends on hwdg_pkg and host_watchdog_with_boot_grace_top_defines.svh
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid, in_stall, op, activity_seq, write_word     | request in
//  out     | out_valid, out_stall, expired, read_word, host_spoke, armed | result out
//  cfg     | cfg_we, cfg_index, cfg_wdata                         | write only
//
// one request per cycle sustained while out_stall is low; each request goes from accept
// into the input register, then the state update lands in the result register
// reset clears watchdog state to disarmed, boot grace on, registers to their defaults
// out_stall holds the result register; the input register still takes a request while
// the result waits, and in_stall rises only when both registers are full
`include "host_watchdog_with_boot_grace_top_defines.svh"

module host_watchdog_with_boot_grace_top
	import hwdg_pkg::*;
#(
	parameter int SEQ_BITS = SEQ_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              op,
	input  logic [SEQ_PORT_BITS-1:0] activity_seq,
	input  logic [15:0]             write_word,
	// result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    expired,
	output logic [15:0]             read_word,
	output logic                    host_spoke,
	output logic                    armed,
	// configuration writes
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [15:0]             cfg_wdata
);

	// only the bits that exist on the port can take part in the compare
	localparam int CMP_BITS = (SEQ_BITS < SEQ_PORT_BITS) ? SEQ_BITS : SEQ_PORT_BITS;

	// input register
	logic                     valid_s1;
	op_t                      op_s1;
	logic [CMP_BITS-1:0]      seq_s1;
	logic [15:0]              word_s1;

	// result register
	logic                     out_valid_q;
	logic                     expired_q;
	logic [15:0]              read_word_q;
	logic                     host_spoke_q;
	logic                     armed_q;

	// configuration
	logic [2:0]               grace_factor_q;
	logic [15:0]              grace_floor_q;

	// watchdog state
	logic [CMP_BITS-1:0]      last_seq_q;
	logic                     in_grace_q;
	logic                     running_q;
	logic [23:0]              seconds_left_q;
	logic [15:0]              period_minutes_q;
	logic [21:0]              period_seconds_q;
	logic                     store_flag_q;

	// next state
	logic [CMP_BITS-1:0]      last_seq_d;
	logic                     in_grace_d;
	logic                     running_d;
	logic [23:0]              seconds_left_d;
	logic [15:0]              period_minutes_d;
	logic [21:0]              period_seconds_d;
	logic                     store_flag_d;
	logic                     expired_d;
	logic [15:0]              read_word_d;

	logic                     out_free;
	logic                     advance;
	logic                     in_accept;
	logic                     heard;
	logic [24:0]              grace_prod;
	logic [24:0]              grace_wide;
	logic [23:0]              grace_win;
	logic [15:0]              wr_minutes;
	logic [15:0]              rd_enc;

	// handshake: the result register frees when empty or taken this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1   <= op_t'(op);
			seq_s1  <= activity_seq[CMP_BITS-1:0];
			word_s1 <= write_word;
		end
	end

	// host activity shows up as a change of the sequence number
	assign heard = (seq_s1 != last_seq_q);

	// boot grace window: larger of period times factor and the floor, clipped to 24 bits
	assign grace_prod = 25'(period_seconds_q) * 25'(grace_factor_q);
	assign grace_wide = (grace_prod < 25'(grace_floor_q)) ? 25'(grace_floor_q) : grace_prod;
	assign grace_win  = (grace_wide > 25'(CNT_MAX)) ? CNT_MAX : grace_wide[23:0];

	// register write decode: 14-bit minutes, optional times-four scale
	assign wr_minutes = word_s1[14] ? {word_s1[13:0], 2'b00} : {2'b00, word_s1[13:0]};

	// register read encode: large values go back out in 4-minute units
	always_comb begin
		rd_enc = period_minutes_q;
		if (period_minutes_q >= SCALE_LIMIT) begin
			rd_enc = (period_minutes_q >> 2) | SCALE_LIMIT;
		end
	end

	always_comb begin
		last_seq_d       = last_seq_q;
		in_grace_d       = in_grace_q;
		running_d        = running_q;
		seconds_left_d   = seconds_left_q;
		period_minutes_d = period_minutes_q;
		period_seconds_d = period_seconds_q;
		store_flag_d     = store_flag_q;
		expired_d        = 1'b0;
		read_word_d      = 16'd0;
		case (op_s1)
			OP_TICK: begin
				// idle ticks do not sample activity
				if (running_q) begin
					if (heard) begin
						last_seq_d     = seq_s1;
						in_grace_d     = 1'b0;
						seconds_left_d = 24'(period_seconds_q);
					end else if (seconds_left_q != 24'd0) begin
						// count parks at zero after the expiry tick
						seconds_left_d = seconds_left_q - 24'd1;
						expired_d      = (seconds_left_q == 24'd1);
					end
				end
			end
			OP_POWER_UP: begin
				in_grace_d = 1'b1;
				last_seq_d = seq_s1;
			end
			OP_ARM: begin
				if (heard) begin
					last_seq_d = seq_s1;
					in_grace_d = 1'b0;
				end
				if (period_seconds_q == 22'd0) begin
					// zero period disarms
					seconds_left_d = 24'd0;
					running_d      = 1'b0;
				end else begin
					seconds_left_d = (in_grace_q && !heard) ? grace_win
						: 24'(period_seconds_q);
					running_d      = 1'b1;
				end
			end
			OP_STOP: begin
				seconds_left_d = 24'd0;
				running_d      = 1'b0;
			end
			OP_WRITE: begin
				// takes effect at once, leaves the running count alone
				period_minutes_d = wr_minutes;
				period_seconds_d = 22'(wr_minutes) * SEC_PER_MIN;
				store_flag_d     = word_s1[15];
			end
			OP_READ: begin
				read_word_d = {store_flag_q, rd_enc[14:0]};
			end
			default: begin
				// unused opcodes only report status
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q       <= '0;
			in_grace_q       <= 1'b1;
			running_q        <= 1'b0;
			seconds_left_q   <= 24'd0;
			period_minutes_q <= 16'd0;
			period_seconds_q <= 22'd0;
			store_flag_q     <= 1'b0;
		end else if (advance) begin
			last_seq_q       <= last_seq_d;
			in_grace_q       <= in_grace_d;
			running_q        <= running_d;
			seconds_left_q   <= seconds_left_d;
			period_minutes_q <= period_minutes_d;
			period_seconds_q <= period_seconds_d;
			store_flag_q     <= store_flag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_factor_q <= GRACE_FACTOR_RST;
			grace_floor_q  <= GRACE_FLOOR_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_GRACE_FACTOR) begin
				grace_factor_q <= cfg_wdata[2:0];
			end
			if (cfg_index == CFG_GRACE_FLOOR) begin
				grace_floor_q <= cfg_wdata;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			expired_q    <= expired_d;
			read_word_q  <= read_word_d;
			host_spoke_q <= !in_grace_d;
			armed_q      <= running_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign expired    = expired_q;
	assign read_word  = read_word_q;
	assign host_spoke = host_spoke_q;
	assign armed      = armed_q;

	// an expiry only comes from a running timer, which keeps running
	`HWDG_ASSERT(a_expired_armed, !(out_valid_q && expired_q) || armed_q, "expiry while disarmed")
	// a stopped timer holds no count
	`HWDG_ASSERT(a_idle_count, running_q || (seconds_left_q == 24'd0), "count left while stopped")
	// an empty input register never stalls the request side
	`HWDG_ASSERT(a_stall_empty, valid_s1 || !in_stall, "stall with empty input register")
	// a result waiting on a stall stays valid
	`HWDG_ASSERT_NEXT(a_hold_result, out_valid_q && out_stall, out_valid_q,
		"stalled result dropped")

endmodule
